// ----- rtl/blpr_pkg.sv -----
// blpr_pkg: shared types and constants for the bounded list unit
// holds beat payload structs, operation and status codes, widths
// no dependencies
`default_nettype none

package blpr_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int POS_W   = 4;
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int ENTRY_W = 5;

   localparam logic [1:0] KIND_APPEND      = 2'd0;
   localparam logic [1:0] KIND_REMOVE_FRONT = 2'd1;
   localparam logic [1:0] KIND_REMOVE_BACK = 2'd2;
   localparam logic [1:0] KIND_REMOVE_AT   = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;
   localparam logic [1:0] STAT_BADPOS = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic signed [31:0] item_value;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic [1:0]         status;
      logic [ENTRY_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic       append;
      logic       remove;
      logic       load;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic pos_bad;
   } flags_type;

endpackage

`default_nettype wire

// ----- rtl/blpr_datapath.sv -----
// blpr_datapath: shifting entry cells, count and result register
// depends on blpr_pkg; driven by commands from blpr_ctrl
`default_nettype none

module blpr_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire blpr_pkg::req_type req_data,
   input  wire blpr_pkg::cmd_type cmd,
   output blpr_pkg::flags_type    flags,
   output blpr_pkg::rsp_type      rsp_data
);
   import blpr_pkg::*;

   logic [31:0]      entries_ff [DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] take_idx;
   logic [31:0]      take_value;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   always_comb begin
      flags.empty   = (count_ff == '0);
      flags.full    = (count_ff == CNT_W'(DEPTH));
      flags.pos_bad = (CMP_W'(req_data.position) >= CMP_W'(count_ff));
   end

   always_comb begin
      unique case (req_data.kind)
         KIND_REMOVE_FRONT: take_idx = '0;
         KIND_REMOVE_BACK:  take_idx = CMP_W'(count_ff - CNT_W'(1));
         default:           take_idx = CMP_W'(req_data.position);
      endcase
      take_value = entries_ff[take_idx[IDX_W-1:0]];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
      rsp_in.removed_value = cmd.remove ? take_value : '0;
      rsp_in.status        = cmd.status;
      rsp_in.entry_count   = ENTRY_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
         if (cmd.remove && (i >= int'(take_idx))) begin
            entries_ff[i] <= entries_ff[i+1];
         end
      end
      if (cmd.append) begin
         entries_ff[count_ff[IDX_W-1:0]] <= req_data.item_value;
      end
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count beyond depth");
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.append |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not grow count");
   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("removal did not shrink count");
   a_fail_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.status != STAT_OK) |=> $stable(count_ff))
      else $error("failed beat changed count");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(cmd.append && cmd.remove))
      else $error("append and removal together");
`endif

endmodule

`default_nettype wire

// ----- rtl/blpr_ctrl.sv -----
// blpr_ctrl: handshake state machine and operation decode
// depends on blpr_pkg; drives commands into blpr_datapath
`default_nettype none

module blpr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_kind,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire blpr_pkg::flags_type flags,
   output blpr_pkg::cmd_type        cmd
);
   import blpr_pkg::*;

   localparam logic OUT_EMPTY = 1'b0;
   localparam logic OUT_FULL  = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;
   logic [1:0] status;

   assign rsp_valid = (state_ff == OUT_FULL);
   assign req_stall = (state_ff == OUT_FULL) && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      priority if (req_kind == KIND_APPEND) begin
         status = flags.full ? STAT_FULL : STAT_OK;
      end else if (flags.empty) begin
         status = STAT_EMPTY;
      end else if (req_kind == KIND_REMOVE_AT && flags.pos_bad) begin
         status = STAT_BADPOS;
      end else begin
         status = STAT_OK;
      end
      cmd.load   = accept;
      cmd.status = status;
      cmd.append = accept && (req_kind == KIND_APPEND) && (status == STAT_OK);
      cmd.remove = accept && (req_kind != KIND_APPEND) && (status == STAT_OK);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         OUT_EMPTY: begin
            if (accept) state_in = OUT_FULL;
         end
         OUT_FULL: begin
            if (!rsp_stall && !accept) state_in = OUT_EMPTY;
         end
         default: state_in = OUT_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OUT_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat left no result");
   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !req_valid) |=> !rsp_valid)
      else $error("result repeated");
   a_no_cmd_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> !(cmd.append || cmd.remove))
      else $error("state change without accepted beat");
`endif

endmodule

`default_nettype wire

// ----- rtl/bounded_list_with_positional_removal_unit.sv -----
// bounded_list_with_positional_removal_unit: top level of the bounded list
// depends on blpr_pkg, blpr_ctrl and blpr_datapath
//
// Ordered list of up to DEPTH (16) signed 32-bit entries held in shifting
// register cells. Each request beat appends at the back, removes the front,
// removes the back or removes at a position, closing the gap in the same
// cycle; every request yields one response beat with the removed value
// (zero when nothing is removed), a status (ok, empty, full, bad position)
// and the new count. The cells shift in the cycle of acceptance and the
// response register holds the result, so a new request is taken each
// cycle while the response side keeps up, and a request is taken even
// while a response waits whenever the response is taken in that same
// cycle.
`default_nettype none

module bounded_list_with_positional_removal_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire blpr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output blpr_pkg::rsp_type      rsp_data
);
   import blpr_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   blpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_data.kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   blpr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .flags    (flags),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
